@@ rtl/dtho_pkg.sv @@
package dtho_pkg;

	// Longest supported walk, in months, from the base month to the target month.
	localparam int MAX_SPAN_MONTHS = 3072;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int OFFSET_W = 23;
	localparam int STATUS_W = 2;

	localparam int MONTHS_PER_YEAR = 12;
	localparam int HOURS_PER_DAY   = 24;
	localparam int LONGEST_MONTH   = 31;

	// The walking year can run past the top of the 14-bit input range.
	localparam int WALK_YEAR_W = YEAR_W + 1;
	localparam int SPAN_W      = $clog2(MAX_SPAN_MONTHS + 1);
	localparam int SUM_W       = $clog2(MAX_SPAN_MONTHS * LONGEST_MONTH + 1);

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = YEAR_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_YEAR  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_MONTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_DAY   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_HOUR  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BEFORE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SPAN   = 2'd2;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
	} base_t;

	// Outcome of the classification of one target against the base instant.
	typedef enum logic [1:0] {
		KIND_WALK,
		KIND_BAD_MONTH,
		KIND_BEFORE,
		KIND_OVER_SPAN
	} kind_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic mod_step;
		logic year_step;
		logic month_step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  rem_ge_year;
		logic  rem_zero;
	} sts_t;

endpackage

@@ rtl/dtho_cfg.sv @@
module dtho_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [dtho_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [dtho_pkg::CFG_DATA_W-1:0]  wr_data,
	output dtho_pkg::base_t                  base
);
	import dtho_pkg::*;

	base_t base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q.year  <= YEAR_W'(2000);
			base_q.month <= MONTH_W'(1);
			base_q.day   <= DAY_W'(1);
			base_q.hour  <= HOUR_W'(0);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_BASE_YEAR:  base_q.year  <= wr_data[YEAR_W-1:0];
				CFG_BASE_MONTH: base_q.month <= wr_data[MONTH_W-1:0];
				CFG_BASE_DAY:   base_q.day   <= wr_data[DAY_W-1:0];
				CFG_BASE_HOUR:  base_q.hour  <= wr_data[HOUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign base = base_q;

endmodule

@@ rtl/dtho_ctrl.sv @@
module dtho_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dtho_pkg::sts_t  sts,
	output dtho_pkg::cmd_t  cmd
);
	import dtho_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_MOD,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && in_valid;
		cmd.classify   = (state_q == ST_CLASSIFY);
		cmd.mod_step   = (state_q == ST_MOD);
		cmd.year_step  = (state_q == ST_YEAR) && sts.rem_ge_year;
		cmd.month_step = (state_q == ST_MONTH) && !sts.rem_zero;
		cmd.finish     = (state_q == ST_FINISH);
		cmd.out_load   = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CLASSIFY;
				end
				ST_CLASSIFY: begin
					state_q <= (sts.kind == KIND_WALK) ? ST_MOD : ST_OUT;
				end
				ST_MOD: begin
					state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (!sts.rem_ge_year) state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (sts.rem_zero) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/dtho_dp.sv @@
module dtho_dp (
	input  logic                          clk,
	input  dtho_pkg::base_t               base,
	input  logic [dtho_pkg::YEAR_W-1:0]   target_year,
	input  logic [dtho_pkg::MONTH_W-1:0]  target_month,
	input  logic [dtho_pkg::DAY_W-1:0]    target_day,
	input  logic [dtho_pkg::HOUR_W-1:0]   target_hour,
	input  dtho_pkg::cmd_t                cmd,
	output dtho_pkg::sts_t                sts,
	output logic [dtho_pkg::OFFSET_W-1:0] hour_offset,
	output logic [dtho_pkg::STATUS_W-1:0] status
);
	import dtho_pkg::*;

	localparam int IDX_W   = YEAR_W + 4;
	localparam int SP_W    = IDX_W + 1;
	localparam int RW      = (SUM_W + 7 > OFFSET_W + 1) ? SUM_W + 7 : OFFSET_W + 1;
	localparam int CENTURY_MOD = 25;
	localparam int RES_W   = $clog2(CENTURY_MOD);
	// Reciprocal of 25 scaled by 2^17; exact for every 14-bit year.
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_25    = (1 << RECIP_SHIFT) / CENTURY_MOD + 1;
	localparam int QUOT_W      = YEAR_W - 4;
	localparam int PROD_W      = YEAR_W + RECIP_SHIFT - 4;
	localparam int DAYS_NORMAL = 365;

	localparam logic signed [RW-1:0] OFF_MIN = RW'(-(1 << (OFFSET_W - 1)));
	localparam logic signed [RW-1:0] OFF_MAX = RW'((1 << (OFFSET_W - 1)) - 1);

	logic [YEAR_W-1:0]      ty_q;
	logic [MONTH_W-1:0]     tm_q;
	logic [DAY_W-1:0]       td_q;
	logic [HOUR_W-1:0]      th_q;

	logic [WALK_YEAR_W-1:0] y_q;
	logic [MONTH_W-1:0]     m_q;
	logic [RES_W-1:0]       r25_q;
	logic [QUOT_W-1:0]      q25_q;
	logic [SPAN_W-1:0]      rem_q;
	logic [SUM_W-1:0]       sum_q;
	logic [OFFSET_W-1:0]    res_q;
	logic [STATUS_W-1:0]    stat_q;
	logic [OFFSET_W-1:0]    out_off_q;
	logic [STATUS_W-1:0]    out_stat_q;

	logic                   same_month;
	logic                   bad_month;
	logic [IDX_W-1:0]       tidx;
	logic [IDX_W-1:0]       bidx;
	logic signed [SP_W-1:0] span;
	kind_t                  kind;
	logic [PROD_W-1:0]      prod25;
	logic [YEAR_W-1:0]      rem_raw;
	logic [WALK_YEAR_W-1:0] y_next;
	logic [RES_W-1:0]       r25_next;
	logic                   leap_cur;
	logic                   leap_next;
	logic                   leap_year_window;
	logic signed [RW-1:0]   day_tot;
	logic signed [RW-1:0]   res_w;
	logic                   in_range;

	// Gregorian rule: divisible by 4, and either not by 25 or also by 16.
	function automatic logic is_leap(input logic [3:0] y_lo, input logic [RES_W-1:0] r25);
		return (y_lo[1:0] == 2'd0) && ((r25 != RES_W'(0)) || (y_lo == 4'd0));
	endfunction

	function automatic logic [SUM_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [SUM_W-1:0] d;
		case (m)
			4'd2:                      d = leap ? SUM_W'(29) : SUM_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11:   d = SUM_W'(30);
			default:                   d = SUM_W'(LONGEST_MONTH);
		endcase
		return d;
	endfunction

	always_comb begin
		same_month = (ty_q == base.year) && (tm_q == base.month);
		bad_month  = (tm_q == MONTH_W'(0)) || (tm_q > MONTH_W'(MONTHS_PER_YEAR)) ||
			(base.month == MONTH_W'(0)) || (base.month > MONTH_W'(MONTHS_PER_YEAR));
		tidx = (IDX_W'(ty_q) << 3) + (IDX_W'(ty_q) << 2) + IDX_W'(tm_q) - IDX_W'(1);
		bidx = (IDX_W'(base.year) << 3) + (IDX_W'(base.year) << 2) +
			IDX_W'(base.month) - IDX_W'(1);
		span = $signed({1'b0, tidx}) - $signed({1'b0, bidx});
		if (same_month) begin
			kind = KIND_WALK;
		end else if (bad_month) begin
			kind = KIND_BAD_MONTH;
		end else if (span[SP_W-1]) begin
			kind = KIND_BEFORE;
		end else if (span > $signed(SP_W'(MAX_SPAN_MONTHS))) begin
			kind = KIND_OVER_SPAN;
		end else begin
			kind = KIND_WALK;
		end
	end

	always_comb begin
		prod25  = PROD_W'(base.year) * PROD_W'(RECIP_25);
		rem_raw = y_q[YEAR_W-1:0] - YEAR_W'(q25_q) * YEAR_W'(CENTURY_MOD);
	end

	always_comb begin
		y_next    = y_q + WALK_YEAR_W'(1);
		r25_next  = (r25_q == RES_W'(CENTURY_MOD - 1)) ? RES_W'(0) : r25_q + RES_W'(1);
		leap_cur  = is_leap(y_q[3:0], r25_q);
		leap_next = is_leap(y_next[3:0], r25_next);
		// Twelve months from m hold the February of this year only when m is at most 2.
		leap_year_window = (m_q > MONTH_W'(2)) ? leap_next : leap_cur;
	end

	always_comb begin
		day_tot  = RW'(sum_q) + RW'(td_q) - RW'(base.day);
		res_w    = (day_tot <<< 4) + (day_tot <<< 3) + RW'(th_q) - RW'(base.hour);
		in_range = (res_w >= OFF_MIN) && (res_w <= OFF_MAX);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ty_q <= target_year;
			tm_q <= target_month;
			td_q <= target_day;
			th_q <= target_hour;
		end
		if (cmd.classify) begin
			y_q   <= WALK_YEAR_W'(base.year);
			m_q   <= base.month;
			sum_q <= '0;
			res_q <= '0;
			q25_q <= QUOT_W'(prod25 >> RECIP_SHIFT);
			rem_q <= same_month ? SPAN_W'(0) : span[SPAN_W-1:0];
			case (kind) inside
				KIND_BEFORE:                    stat_q <= STATUS_BEFORE;
				KIND_BAD_MONTH, KIND_OVER_SPAN: stat_q <= STATUS_SPAN;
				default:                        stat_q <= STATUS_OK;
			endcase
		end
		if (cmd.mod_step) begin
			r25_q <= (rem_raw >= YEAR_W'(CENTURY_MOD)) ?
				RES_W'(rem_raw - YEAR_W'(CENTURY_MOD)) : RES_W'(rem_raw);
		end
		if (cmd.year_step) begin
			sum_q <= sum_q + SUM_W'(DAYS_NORMAL) + SUM_W'(leap_year_window);
			y_q   <= y_next;
			r25_q <= r25_next;
			rem_q <= rem_q - SPAN_W'(MONTHS_PER_YEAR);
		end
		if (cmd.month_step) begin
			sum_q <= sum_q + month_days(m_q, leap_cur);
			rem_q <= rem_q - SPAN_W'(1);
			if (m_q == MONTH_W'(MONTHS_PER_YEAR)) begin
				m_q   <= MONTH_W'(1);
				y_q   <= y_next;
				r25_q <= r25_next;
			end else begin
				m_q <= m_q + MONTH_W'(1);
			end
		end
		if (cmd.finish) begin
			res_q  <= in_range ? res_w[OFFSET_W-1:0] : '0;
			stat_q <= in_range ? STATUS_OK : STATUS_SPAN;
		end
		if (cmd.out_load) begin
			out_off_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign sts.kind        = kind;
	assign sts.rem_ge_year = (rem_q >= SPAN_W'(MONTHS_PER_YEAR));
	assign sts.rem_zero    = (rem_q == SPAN_W'(0));
	assign hour_offset     = out_off_q;
	assign status          = out_stat_q;

endmodule

@@ rtl/date_to_hour_offset.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  target year, month, day, hour
// m_axis    out        m_axis_tvalid / m_axis_tready  hour offset (tdata), status (tuser)
// cfg       in         cfg_valid / cfg_ready          register index, write data
//
// After its accepting edge a transaction is classified; a walking target then takes a
// modulo step, year steps over the whole years and month steps over the leftover months
// of the walk from the base month to the target month, each adding to the shared day
// accumulator, and a finish step before its result is loaded. The default span limit is
// 3072 months (256 years). Rejected targets skip the walk. The next input transaction
// can be taken in the cycle after the result has been loaded.
// Reset is asynchronous and active low; the base registers return to 2000-01-01 hour 0.
// The result sits in an output register, so a new input transaction is taken while the
// previous result is still waiting on m_axis_tready.
module date_to_hour_offset (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_axis_tdata, from bit 0: target_year[13:0], target_month[3:0],
	// target_day[4:0], target_hour[4:0], zero pad[3:0].
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dtho_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// m_axis_tdata, from bit 0: hour_offset[22:0] (two's complement), zero pad[0].
	// m_axis_tuser, from bit 0: status[1:0].
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dtho_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [dtho_pkg::STATUS_W-1:0]       m_axis_tuser,
	// Configuration writes: 0 base_year, 1 base_month, 2 base_day, 3 base_hour.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtho_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dtho_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dtho_pkg::*;

	base_t                base;
	cmd_t                 cmd;
	sts_t                 sts;
	logic [OFFSET_W-1:0]  hour_offset;
	logic [STATUS_W-1:0]  status;

	// The base registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	dtho_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.base     (base)
	);

	dtho_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath captures the input fields on the accepting edge and walks from there.
	dtho_dp u_dp (
		.clk          (clk),
		.base         (base),
		.target_year  (s_axis_tdata[13:0]),
		.target_month (s_axis_tdata[17:14]),
		.target_day   (s_axis_tdata[22:18]),
		.target_hour  (s_axis_tdata[27:23]),
		.cmd          (cmd),
		.sts          (sts),
		.hour_offset  (hour_offset),
		.status       (status)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - OFFSET_W){1'b0}}, hour_offset};
	assign m_axis_tuser = status;

endmodule
